[sv/srr_pkg.sv]
// Shared types, constants and helpers for the selective-repeat receiver.
// Depends on nothing; every other file in this folder refers to it by scoped names.
package srr_pkg;

    // The reorder depth must be a power of two, since a slot index is the low bits of a number.
    localparam int WINDOW_DEPTH  = 32;
    localparam int IDX_W         = $clog2(WINDOW_DEPTH);
    localparam int SEQ_W         = 32;
    localparam int TAG_W         = 16;
    localparam int WIN_W         = 6;
    localparam int CFG_W         = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int WINDOW_RESET  = 32;
    localparam int SLOT_W        = SEQ_W + TAG_W + 1;
    localparam int IN_DATA_W     = ((SEQ_W + TAG_W + 7) / 8) * 8;
    localparam int OUT_DATA_W    = ((SLOT_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_START_SEQ   = 1'b1;

    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [SEQ_W-1:0] seq_t;

    typedef struct packed {
        logic             fin;
        logic [TAG_W-1:0] tag;
        seq_t             seq;
    } slot_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic  wr_en;
        idx_t  wr_idx;
        slot_t wr_data;
        logic  clr_en;
        idx_t  clr_idx;
        idx_t  rd_idx;
        idx_t  chk_idx;
    } slot_ctrl_t;

    function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_W-1:0] v);
        if (int'(v) > WINDOW_DEPTH) begin
            return WIN_W'(WINDOW_DEPTH);
        end else begin
            return v;
        end
    endfunction

endpackage

[sv/srr_alu.sv]
// Shared 32-bit adder of the receiver: adds, or subtracts to give an unsigned less-than.
// Depends on srr_pkg for widths and the operation code.
module srr_alu (
    input  srr_pkg::alu_op_t op,
    input  srr_pkg::seq_t    a,
    input  srr_pkg::seq_t    b,
    output srr_pkg::seq_t    sum,
    output logic             lt
);

    logic [srr_pkg::SEQ_W-1:0] b_eff;
    logic                      cin;
    logic [srr_pkg::SEQ_W:0]   full;

    assign b_eff = (op == srr_pkg::ALU_SUB) ? ~b : b;
    assign cin   = (op == srr_pkg::ALU_SUB);
    assign full  = {1'b0, a} + {1'b0, b_eff} + {{srr_pkg::SEQ_W{1'b0}}, cin};
    assign sum   = full[srr_pkg::SEQ_W-1:0];
    assign lt    = (op == srr_pkg::ALU_SUB) && !full[srr_pkg::SEQ_W];

endmodule

[sv/srr_slot_store.sv]
// Reorder slots: packet memory with registered read and per-slot valid flip-flops.
// Depends on srr_pkg for the slot layout and the control struct.
module srr_slot_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  srr_pkg::slot_ctrl_t ctrl,
    output srr_pkg::slot_t      rd_data,
    output logic                head_valid,
    output logic                chk_valid
);

    srr_pkg::slot_t                     mem [srr_pkg::WINDOW_DEPTH];
    srr_pkg::slot_t                     rd_data_reg;
    logic [srr_pkg::WINDOW_DEPTH-1:0]   valid_reg;
    logic [srr_pkg::WINDOW_DEPTH-1:0]   valid_next;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[ctrl.wr_idx] <= ctrl.wr_data;
        end
        rd_data_reg <= mem[ctrl.rd_idx];
    end

    always_comb begin
        valid_next = valid_reg;
        if (ctrl.wr_en) begin
            valid_next[ctrl.wr_idx] = 1'b1;
        end
        if (ctrl.clr_en) begin
            valid_next[ctrl.clr_idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign rd_data    = rd_data_reg;
    assign head_valid = valid_reg[ctrl.rd_idx];
    assign chk_valid  = valid_reg[ctrl.chk_idx];

endmodule

[sv/selective_repeat_receiver.sv]
// Top level of the selective-repeat receiver: sequencer, window registers and result register.
// Depends on srr_pkg, srr_alu and srr_slot_store.
//
// Channel   Ports                                 Item
// input     s_tvalid s_tready s_tdata s_tlast     one arriving packet descriptor
// result    m_tvalid m_tready m_tdata m_tuser     one acknowledgment or one in-order delivery
//           m_tlast
// config    cfg_we cfg_index cfg_wdata            one register write
//
// An item holds the input until the sequencer is idle again; its acknowledgment is loaded in ACK
// after UPPER, LOW and HIGH; each packet it releases in order takes a DELIVER state, all but the
// first after a WAIT, as the shared adder also does each counter step and slots are reread.
// Reset sets the expected number to zero, the window to its full width and clears all slots.
// A stalled result register holds the sequencer in place; no new item is taken until the
// last result of the current one has been loaded.
module selective_repeat_receiver (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [srr_pkg::IN_DATA_W-1:0]        s_tdata,   // pkt_seq, payload_tag
    input  logic                                 s_tlast,   // is_fin
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [srr_pkg::OUT_DATA_W-1:0]       m_tdata,   // out_seq, out_tag, out_fin
    output logic                                 m_tuser,   // result_kind
    output logic                                 m_tlast,   // last
    input  logic                                 cfg_we,
    input  logic [srr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [srr_pkg::CFG_W-1:0]            cfg_wdata
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_UPPER   = 7'b0000010,
        S_LOW     = 7'b0000100,
        S_HIGH    = 7'b0001000,
        S_ACK     = 7'b0010000,
        S_DELIVER = 7'b0100000,
        S_WAIT    = 7'b1000000
    } state_t;

    state_t                          state_reg, state_next;
    srr_pkg::seq_t                   seq_reg, seq_next;
    logic [srr_pkg::TAG_W-1:0]       tag_reg, tag_next;
    logic                            fin_reg, fin_next;
    srr_pkg::seq_t                   upper_reg, upper_next;
    logic                            in_lo_reg, in_lo_next;
    logic                            ack_reg, ack_next;
    srr_pkg::seq_t                   expected_reg, expected_next;
    logic [srr_pkg::WIN_W-1:0]       window_reg, window_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    srr_pkg::slot_t                  m_slot_reg, m_slot_next;
    logic                            m_tuser_reg, m_tuser_next;
    logic                            m_tlast_reg, m_tlast_next;

    srr_pkg::alu_op_t                alu_op;
    srr_pkg::seq_t                   alu_a, alu_b, alu_sum;
    logic                            alu_lt;
    srr_pkg::slot_ctrl_t             slot_ctrl;
    srr_pkg::slot_t                  rd_data;
    logic                            head_valid, chk_valid;
    logic                            out_free, out_load;

    srr_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .lt  (alu_lt)
    );

    srr_slot_store u_slots (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (slot_ctrl),
        .rd_data    (rd_data),
        .head_valid (head_valid),
        .chk_valid  (chk_valid)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        alu_op = srr_pkg::ALU_ADD;
        alu_a  = expected_reg;
        alu_b  = {{(srr_pkg::SEQ_W-srr_pkg::WIN_W){1'b0}}, window_reg};
        case (state_reg)
            S_LOW: begin
                alu_op = srr_pkg::ALU_SUB;
                alu_a  = seq_reg;
                alu_b  = expected_reg;
            end
            S_HIGH: begin
                alu_op = srr_pkg::ALU_SUB;
                alu_a  = seq_reg;
                alu_b  = upper_reg;
            end
            S_DELIVER: begin
                alu_b  = srr_pkg::SEQ_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        seq_next      = seq_reg;
        tag_next      = tag_reg;
        fin_next      = fin_reg;
        upper_next    = upper_reg;
        in_lo_next    = in_lo_reg;
        ack_next      = ack_reg;
        expected_next = expected_reg;
        window_next   = window_reg;
        m_slot_next   = m_slot_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        out_load      = 1'b0;

        slot_ctrl.wr_en   = 1'b0;
        slot_ctrl.wr_idx  = seq_reg[srr_pkg::IDX_W-1:0];
        slot_ctrl.wr_data = '{fin: fin_reg, tag: tag_reg, seq: seq_reg};
        slot_ctrl.clr_en  = 1'b0;
        slot_ctrl.clr_idx = expected_reg[srr_pkg::IDX_W-1:0];
        slot_ctrl.rd_idx  = expected_reg[srr_pkg::IDX_W-1:0];
        slot_ctrl.chk_idx = alu_sum[srr_pkg::IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    seq_next   = s_tdata[srr_pkg::SEQ_W-1:0];
                    tag_next   = s_tdata[srr_pkg::SEQ_W +: srr_pkg::TAG_W];
                    fin_next   = s_tlast;
                    state_next = S_UPPER;
                end
            end
            S_UPPER: begin
                upper_next = alu_sum;
                state_next = S_LOW;
            end
            S_LOW: begin
                in_lo_next = !alu_lt;
                state_next = S_HIGH;
            end
            S_HIGH: begin
                ack_next        = alu_lt;
                slot_ctrl.wr_en = in_lo_reg && alu_lt;
                state_next      = S_ACK;
            end
            S_ACK: begin
                if (!ack_reg || out_free) begin
                    if (ack_reg) begin
                        out_load     = 1'b1;
                        m_slot_next  = '{fin: 1'b0, tag: '0, seq: seq_reg};
                        m_tuser_next = srr_pkg::KIND_ACK;
                        m_tlast_next = !head_valid;
                    end
                    state_next = head_valid ? S_DELIVER : S_IDLE;
                end
            end
            S_DELIVER: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    m_slot_next      = rd_data;
                    m_tuser_next     = srr_pkg::KIND_DELIVER;
                    m_tlast_next     = !chk_valid;
                    slot_ctrl.clr_en = 1'b1;
                    expected_next    = alu_sum;
                    state_next       = chk_valid ? S_WAIT : S_IDLE;
                end
            end
            S_WAIT: begin
                state_next = S_DELIVER;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we) begin
            case (cfg_index)
                srr_pkg::REG_WINDOW_SIZE: begin
                    window_next = srr_pkg::clamp_window(cfg_wdata[srr_pkg::WIN_W-1:0]);
                end
                srr_pkg::REG_START_SEQ: begin
                    expected_next = cfg_wdata[srr_pkg::SEQ_W-1:0];
                end
                default: begin
                end
            endcase
        end

        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            expected_reg <= '0;
            window_reg   <= srr_pkg::clamp_window(srr_pkg::WIN_W'(srr_pkg::WINDOW_RESET));
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            expected_reg <= expected_next;
            window_reg   <= window_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        seq_reg     <= seq_next;
        tag_reg     <= tag_next;
        fin_reg     <= fin_next;
        upper_reg   <= upper_next;
        in_lo_reg   <= in_lo_next;
        ack_reg     <= ack_next;
        m_slot_reg  <= m_slot_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(srr_pkg::OUT_DATA_W-srr_pkg::SLOT_W){1'b0}}, m_slot_reg};
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // A delivery is only attempted on a slot that holds a packet.
    a_deliver_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DELIVER) |-> head_valid)
        else $error("delivery state entered on an empty head slot");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register loaded while a result is pending");

    // The expected number moves only on a delivery or a start_seq write.
    a_expected_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(expected_reg) |->
            ($past(state_reg) == S_DELIVER ||
             $past(cfg_we && cfg_index == srr_pkg::REG_START_SEQ)))
        else $error("expected sequence number changed outside a delivery");

    // Acknowledgments carry no tag and no FIN mark.
    a_ack_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg == srr_pkg::KIND_ACK) |->
            (m_slot_reg.tag == '0 && !m_slot_reg.fin))
        else $error("acknowledgment carries payload fields");

endmodule
